// ===== design/haptic_velocity_filter_spring_lock_unit_assert.svh =====
// Assertion macros shared by the haptic servo block.
`ifndef HAPTIC_VELOCITY_FILTER_SPRING_LOCK_UNIT_ASSERT_SVH
`define HAPTIC_VELOCITY_FILTER_SPRING_LOCK_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HVSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HVSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HVSL_ASSERT(lbl, prop, msg)
`define HVSL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/hvsl_pkg.sv =====
// Shared types, constants and saturation helpers for the haptic servo block.
package hvsl_pkg;

  localparam int IN_W  = 200;
  localparam int OUT_W = 200;
  localparam int GAIN_W = 24;
  localparam int VEL_SHIFT = 22;
  localparam int FORCE_SHIFT = 24;

  localparam logic [GAIN_W-1:0] COEF_B0 = 24'd921;
  localparam logic [GAIN_W-1:0] COEF_B1 = 24'd2763;
  localparam logic [GAIN_W-1:0] COEF_A1 = 24'd11529303;
  localparam logic [GAIN_W-1:0] COEF_A2 = 24'd10604039;
  localparam logic [GAIN_W-1:0] COEF_A3 = 24'd3261491;

  localparam logic [GAIN_W-1:0] SPRING_RESET = 24'd671089;
  localparam logic [GAIN_W-1:0] DAMP_RESET   = 24'd16777;

  localparam logic REG_SPRING = 1'b0;
  localparam logic REG_DAMP   = 1'b1;

  typedef enum logic [2:0] {
    TERM_B0, TERM_B1, TERM_A1, TERM_A2, TERM_A3, TERM_SPRING, TERM_DAMP
  } term_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_DIFF, DP_RAW, DP_MUL, DP_PROD, DP_ACC, DP_RND22, DP_RND24,
    DP_STV, DP_STF, DP_LOADC, DP_BTN, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    term_t       term;
    logic [1:0]  axis;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic lock;
  } dp_stat_t;

  function automatic logic signed [63:0] sat64(input logic signed [66:0] x);
    if (x[66:63] == {4{x[66]}}) return x[63:0];
    else if (x[66]) return {1'b1, {63{1'b0}}};
    else return {1'b0, {63{1'b1}}};
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [45:0] x);
    if (x[45:39] == {7{x[45]}}) return x[39:0];
    else if (x[45]) return {1'b1, {39{1'b0}}};
    else return {1'b0, {39{1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    if (x[39:31] == {9{x[39]}}) return x[31:0];
    else if (x[39]) return {1'b1, {31{1'b0}}};
    else return {1'b0, {31{1'b1}}};
  endfunction

endpackage

// ===== design/hvsl_dp.sv =====
// Datapath: axis state, shared 41x24 multiplier, saturating accumulator.
module hvsl_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  hvsl_pkg::dp_cmd_t           cmd,
  output hvsl_pkg::dp_stat_t          stat,
  input  logic                        in_mode,
  input  logic [hvsl_pkg::IN_W-1:0]   in_data,
  input  logic [hvsl_pkg::GAIN_W-1:0] spring_gain,
  input  logic [hvsl_pkg::GAIN_W-1:0] damping_gain,
  output logic [hvsl_pkg::OUT_W-1:0]  out_data
);
  import hvsl_pkg::*;

  localparam logic signed [66:0] HALF_V = 67'sd1 <<< (VEL_SHIFT - 1);
  localparam logic signed [66:0] HALF_F = 67'sd1 <<< (FORCE_SHIFT - 1);

  logic               mode_r;
  logic signed [31:0] pos_in [3];
  logic signed [31:0] cmd_in [3];
  logic [1:0]         btn_in;

  logic signed [31:0] p1 [3];
  logic signed [31:0] p2 [3];
  logic signed [39:0] raw1 [3];
  logic signed [39:0] raw2 [3];
  logic signed [39:0] raw3 [3];
  logic signed [39:0] filt1 [3];
  logic signed [39:0] filt2 [3];
  logic signed [39:0] filt3 [3];
  logic signed [31:0] held [3];
  logic signed [31:0] target [3];
  logic               lock;
  logic [1:0]         prev_btn;
  logic               event_flag;

  logic signed [35:0] diff;
  logic signed [39:0] r_cur;
  logic [47:0]        plo;
  logic signed [41:0] phi;
  logic signed [65:0] prod;
  logic signed [63:0] acc;

  logic signed [31:0] force_o [3];
  logic signed [31:0] vel_o [3];
  logic               lock_o;
  logic               event_o;

  logic [1:0]         ax;
  logic signed [40:0] opa;
  logic [GAIN_W-1:0]  coef;
  logic               neg;
  logic signed [65:0] psum;
  logic signed [39:0] vnew;

  assign ax = cmd.axis;
  assign stat.mode = mode_r;
  assign stat.lock = lock;

  always_comb begin
    opa  = '0;
    coef = '0;
    neg  = 1'b0;
    case (cmd.term)
      TERM_B0: begin
        opa  = 41'(r_cur) + 41'(raw3[ax]);
        coef = COEF_B0;
      end
      TERM_B1: begin
        opa  = 41'(raw1[ax]) + 41'(raw2[ax]);
        coef = COEF_B1;
      end
      TERM_A1: begin
        opa  = 41'(filt1[ax]);
        coef = COEF_A1;
      end
      TERM_A2: begin
        opa  = 41'(filt2[ax]);
        coef = COEF_A2;
        neg  = 1'b1;
      end
      TERM_A3: begin
        opa  = 41'(filt3[ax]);
        coef = COEF_A3;
      end
      TERM_SPRING: begin
        opa  = 41'(target[ax]) - 41'(pos_in[ax]);
        coef = spring_gain;
      end
      TERM_DAMP: begin
        opa  = 41'(filt1[ax]);
        coef = damping_gain;
        neg  = 1'b1;
      end
      default: begin
        opa  = '0;
        coef = '0;
      end
    endcase
    psum = (66'(phi) <<< 24) + $signed({18'b0, plo});
    vnew = sat40(46'(acc >>> VEL_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        p1[i] <= '0;
        p2[i] <= '0;
        raw1[i] <= '0;
        raw2[i] <= '0;
        raw3[i] <= '0;
        filt1[i] <= '0;
        filt2[i] <= '0;
        filt3[i] <= '0;
        held[i] <= '0;
        target[i] <= '0;
      end
      lock       <= 1'b1;
      prev_btn   <= '0;
      event_flag <= 1'b0;
    end else begin
      case (cmd.op)
        DP_STV: begin
          p2[ax]    <= p1[ax];
          p1[ax]    <= pos_in[ax];
          raw3[ax]  <= raw2[ax];
          raw2[ax]  <= raw1[ax];
          raw1[ax]  <= r_cur;
          filt3[ax] <= filt2[ax];
          filt2[ax] <= filt1[ax];
          filt1[ax] <= vnew;
        end
        DP_STF: begin
          held[ax] <= sat32(40'(acc >>> FORCE_SHIFT));
          if (mode_r) begin
            target[ax] <= pos_in[ax];
          end
        end
        DP_LOAD: event_flag <= 1'b0;
        DP_BTN: begin
          if (btn_in != prev_btn) begin
            if (btn_in == 2'b11) begin
              lock <= ~lock;
            end
            event_flag <= 1'b1;
            prev_btn   <= btn_in;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        mode_r <= in_mode;
        for (int i = 0; i < 3; i++) begin
          pos_in[i] <= in_data[32*i +: 32];
          cmd_in[i] <= in_data[96 + 32*i +: 32];
        end
        btn_in <= in_data[193:192];
      end
      DP_DIFF: begin
        diff <= 36'(pos_in[ax]) + (36'(pos_in[ax]) <<< 1) - (36'(p1[ax]) <<< 2)
                + 36'(p2[ax]);
        acc  <= '0;
      end
      DP_RAW:   r_cur <= sat40((46'(diff) <<< 9) - (46'(diff) <<< 3) - (46'(diff) <<< 2));
      DP_MUL: begin
        plo <= 48'(opa[23:0]) * 48'(coef);
        phi <= 42'($signed(opa[40:24])) * 42'($signed({1'b0, coef}));
      end
      DP_PROD:  prod <= neg ? -psum : psum;
      DP_ACC:   acc <= sat64(67'(acc) + 67'(prod));
      DP_RND22: acc <= sat64(67'(acc) + HALF_V);
      DP_RND24: acc <= sat64(67'(acc) + HALF_F);
      DP_STV:   acc <= '0;
      DP_LOADC: acc <= $signed({40'(cmd_in[ax]), 24'b0});
      DP_OUT: begin
        for (int i = 0; i < 3; i++) begin
          force_o[i] <= held[i];
          vel_o[i]   <= sat32(filt1[i]);
        end
        lock_o  <= lock;
        event_o <= event_flag;
      end
      default: ;
    endcase
  end

  assign out_data = {6'b0, event_o, lock_o, vel_o[2], vel_o[1], vel_o[0],
                     force_o[2], force_o[1], force_o[0]};

endmodule

// ===== design/hvsl_ctrl.sv =====
// Controller: sequences axes and product terms, owns the item handshakes.
`include "haptic_velocity_filter_spring_lock_unit_assert.svh"
module hvsl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  hvsl_pkg::dp_stat_t stat,
  output hvsl_pkg::dp_cmd_t  cmd
);
  import hvsl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIFF, S_RAW, S_MUL, S_PROD, S_ACC, S_RND, S_STV, S_STF,
    S_LOADC, S_BTN, S_OUT
  } state_t;

  state_t     state;
  term_t      term;
  logic [1:0] axis;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.term = term;
    cmd.axis = axis;
    unique case (state)
      S_IDLE:  cmd.op = s_tvalid ? DP_LOAD : DP_NOP;
      S_START: cmd.op = DP_NOP;
      S_DIFF:  cmd.op = DP_DIFF;
      S_RAW:   cmd.op = DP_RAW;
      S_MUL:   cmd.op = DP_MUL;
      S_PROD:  cmd.op = DP_PROD;
      S_ACC:   cmd.op = DP_ACC;
      S_RND:   cmd.op = (term == TERM_A3) ? DP_RND22 : DP_RND24;
      S_STV:   cmd.op = DP_STV;
      S_STF:   cmd.op = DP_STF;
      S_LOADC: cmd.op = DP_LOADC;
      S_BTN:   cmd.op = DP_BTN;
      S_OUT:   cmd.op = out_free ? DP_OUT : DP_NOP;
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      term     <= TERM_B0;
      axis     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (s_tvalid) begin
          state <= S_START;
        end
        S_START: begin
          axis  <= '0;
          state <= stat.mode ? S_LOADC : S_DIFF;
        end
        S_DIFF: state <= S_RAW;
        S_RAW: begin
          term  <= TERM_B0;
          state <= S_MUL;
        end
        S_MUL:  state <= S_PROD;
        S_PROD: state <= S_ACC;
        S_ACC: begin
          if (term == TERM_A3 || term == TERM_DAMP) begin
            state <= S_RND;
          end else begin
            term  <= term_t'(term + 3'd1);
            state <= S_MUL;
          end
        end
        S_RND: state <= (term == TERM_A3) ? S_STV : S_STF;
        S_STV, S_STF: begin
          if (state == S_STV && stat.lock) begin
            term  <= TERM_SPRING;
            state <= S_MUL;
          end else if (axis == 2'd2) begin
            state <= stat.mode ? S_OUT : S_BTN;
          end else begin
            axis  <= axis + 2'd1;
            state <= stat.mode ? S_LOADC : S_DIFF;
          end
        end
        S_LOADC: begin
          term  <= TERM_DAMP;
          state <= S_MUL;
        end
        S_BTN: state <= S_OUT;
        S_OUT: if (out_free) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HVSL_ASSERT_ALWAYS(a_axis_range, rst || axis != 2'd3, "axis counter out of range")
  `HVSL_ASSERT(a_load_start, (state == S_IDLE && s_tvalid) |=> (state == S_START),
               "accepted item did not start")
  `HVSL_ASSERT(a_out_set, (state == S_OUT && out_free) |=> (m_tvalid && state == S_IDLE),
               "result not presented")

endmodule

// ===== design/haptic_velocity_filter_spring_lock_unit.sv =====
// Top level of the haptic servo block: config registers, controller, datapath.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata: servo sample or feedback, s_tuser: mode
//  m_*       out  m_tvalid/m_tready    m_tdata: forces, velocities, lock, button event
//  apb       in   psel/penable/pready  spring_gain @0x0, damping_gain @0x4
//
// One item at a time. Each product term steps through MUL, PROD and ACC on the one shared
// 41x24 multiplier: five filter terms per axis for a servo sample, plus two spring terms
// with lock on; a feedback item uses one damping term per axis.
// A finished result waits in the output register while the next item is accepted.
// Reset: synchronous; histories clear, lock comes up on, gains load defaults.
module haptic_velocity_filter_spring_lock_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // pos_x, pos_y, pos_z, cmd_force_x, cmd_force_y, cmd_force_z, btn_a, btn_b
  input  logic [hvsl_pkg::IN_W-1:0]  s_tdata,
  // mode
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // force_x, force_y, force_z, vel_x, vel_y, vel_z, lock_active, btn_changed
  output logic [hvsl_pkg::OUT_W-1:0] m_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import hvsl_pkg::*;

  logic [GAIN_W-1:0] spring_gain;
  logic [GAIN_W-1:0] damping_gain;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DAMP) ? {8'b0, damping_gain} : {8'b0, spring_gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_gain  <= SPRING_RESET;
      damping_gain <= DAMP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_DAMP) begin
        damping_gain <= pwdata[GAIN_W-1:0];
      end else begin
        spring_gain <= pwdata[GAIN_W-1:0];
      end
    end
  end

  hvsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hvsl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_mode      (s_tuser),
    .in_data      (s_tdata),
    .spring_gain  (spring_gain),
    .damping_gain (damping_gain),
    .out_data     (m_tdata)
  );

endmodule

// ===== tb/haptic_velocity_filter_spring_lock_unit_tb.sv =====
// Self-checking testbench for the haptic servo block: directed table, random servo and feedback traffic.
module haptic_velocity_filter_spring_lock_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hvsl_pkg::*;

  localparam longint MAX40 = 64'sd549755813887;
  localparam longint MIN40 = -64'sd549755813888;
  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [2:0] ADDR_SPRING = 3'd0;
  localparam logic [2:0] ADDR_DAMP = 3'd4;
  localparam bit MODE_SERVO = 1'b0;
  localparam bit MODE_FEEDBACK = 1'b1;

  logic clk = 0;
  logic rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  haptic_velocity_filter_spring_lock_unit uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // servo model state
  longint pos_h[2][3], raw_h[3][3], filt_h[3][3], held_f[3], lock_tgt[3];
  bit lock_on;
  bit [1:0] prev_btn;
  longint spring_g, damp_g;

  logic [OUT_W-1:0] expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int cycle_cnt = 0;
  int hold_cnt = 0;

  typedef struct {
    bit mode;
    logic [IN_W-1:0] data;
    bit typed;
    logic [OUT_W-1:0] result;
  } row_t;
  row_t rows[$];

  function automatic longint sadd(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint round_down_shift(longint x, int n);
    x = sadd(x, 64'sd1 <<< (n - 1));
    return x >>> n;
  endfunction

  function automatic logic [IN_W-1:0] pack_in(logic [31:0] px, py, pz, cx, cy, cz,
                                               bit grey, bit white);
    return {6'd0, white, grey, cz, cy, cx, pz, py, px};
  endfunction

  function automatic logic [OUT_W-1:0] pack_out(logic [31:0] fx, fy, fz, vx, vy, vz,
                                                bit lk, bit ev);
    return {6'd0, ev, lk, vz, vy, vx, fz, fy, fx};
  endfunction

  function automatic logic [OUT_W-1:0] servo_step(bit mode, logic [IN_W-1:0] d);
    longint p, r, acc, v, s, c;
    longint f[3];
    logic [31:0] fo[3], vo[3];
    bit ev;
    bit [1:0] btn;
    ev = 0;
    for (int a = 0; a < 3; a++) begin
      if (mode == MODE_SERVO) begin
        p = longint'($signed(d[32*a +: 32]));
        r = clip((3 * p - 4 * pos_h[0][a] + pos_h[1][a]) * 500, MIN40, MAX40);
        acc = (r + raw_h[2][a]) * COEF_B0;
        acc = sadd(acc, (raw_h[0][a] + raw_h[1][a]) * COEF_B1);
        acc = sadd(acc, filt_h[0][a] * COEF_A1);
        acc = sadd(acc, -(filt_h[1][a] * COEF_A2));
        acc = sadd(acc, filt_h[2][a] * COEF_A3);
        v = clip(round_down_shift(acc, VEL_SHIFT), MIN40, MAX40);
        pos_h[1][a] = pos_h[0][a];
        pos_h[0][a] = p;
        raw_h[2][a] = raw_h[1][a];
        raw_h[1][a] = raw_h[0][a];
        raw_h[0][a] = r;
        filt_h[2][a] = filt_h[1][a];
        filt_h[1][a] = filt_h[0][a];
        filt_h[0][a] = v;
        if (lock_on) begin
          s = (lock_tgt[a] - p) * spring_g;
          s = sadd(s, -(v * damp_g));
          held_f[a] = clip(round_down_shift(s, FORCE_SHIFT), MIN32, MAX32);
        end
      end else begin
        c = longint'($signed(d[96 + 32*a +: 32])) * (64'sd1 <<< 24);
        c = sadd(c, -(filt_h[0][a] * damp_g));
        held_f[a] = clip(round_down_shift(c, FORCE_SHIFT), MIN32, MAX32);
        lock_tgt[a] = longint'($signed(d[32*a +: 32]));
      end
      f[a] = held_f[a];
      fo[a] = f[a][31:0];
      v = clip(filt_h[0][a], MIN32, MAX32);
      vo[a] = v[31:0];
    end
    if (mode == MODE_SERVO) begin
      btn = {d[193], d[192]};
      if (btn != prev_btn) begin
        if (btn == 2'b11) lock_on = !lock_on;
        ev = 1;
        prev_btn = btn;
      end
    end
    return pack_out(fo[0], fo[1], fo[2], vo[0], vo[1], vo[2], lock_on, ev);
  endfunction

  task automatic send_item(bit mode, logic [IN_W-1:0] d, bit typed, logic [OUT_W-1:0] res);
    logic [OUT_W-1:0] pred;
    if (burst_left == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_tuser <= mode;
    s_tdata <= d;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    pred = servo_step(mode, d);
    expected_results.push_back(typed ? res : pred);
    burst_left--;
  endtask

  task automatic drain_and_idle();
    s_tvalid <= 0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [23:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= addr;
    pwdata <= {8'd0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr == ADDR_SPRING) spring_g = longint'(val);
    else damp_g = longint'(val);
    @(posedge clk);
  endtask

  task automatic add_row(bit mode, logic [IN_W-1:0] d, bit typed = 0,
                         logic [OUT_W-1:0] res = '0);
    row_t rw;
    rw.mode = mode;
    rw.data = d;
    rw.typed = typed;
    rw.result = res;
    rows.push_back(rw);
  endtask

  // result checker
  always @(posedge clk) begin
    logic [OUT_W-1:0] e;
    string names[8];
    names = '{"force_x", "force_y", "force_z", "vel_x", "vel_y", "vel_z",
              "lock_active", "btn_changed"};
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no item pending: %h", m_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        for (int i = 0; i < 6; i++)
          if (m_tdata[32*i +: 32] !== e[32*i +: 32]) begin
            $error("%s expected %0d got %0d", names[i], $signed(e[32*i +: 32]),
                   $signed(m_tdata[32*i +: 32]));
            errors++;
          end
        for (int i = 6; i < 8; i++)
          if (m_tdata[186 + i] !== e[186 + i]) begin
            $error("%s expected %0b got %0b", names[i], e[186 + i], m_tdata[186 + i]);
            errors++;
          end
      end
    end
  end

  // receiver: random stalls, clean stretches, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      cycle_cnt++;
      if (cycle_cnt == 3000) hold_cnt = 600;
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 0;
      end else if ((cycle_cnt / 500) % 3 == 2) begin
        m_tready <= 1;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog on accepted items
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("haptic_velocity_filter_spring_lock_unit verification failed");
      $finish;
    end
  end

  initial begin
    longint walk[3];
    longint dlt;
    logic [31:0] pv[3], cv[3];
    bit g, w, md;
    logic [23:0] sg_set[4], dg_set[4];

    rst <= 1;
    s_tvalid <= 0;
    s_tuser <= 0;
    s_tdata <= '0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= '0;
    pwdata <= '0;
    foreach (pos_h[i, a]) pos_h[i][a] = 0;
    foreach (raw_h[i, a]) raw_h[i][a] = 0;
    foreach (filt_h[i, a]) filt_h[i][a] = 0;
    for (int a = 0; a < 3; a++) begin
      held_f[a] = 0;
      lock_tgt[a] = 0;
      walk[a] = 0;
    end
    lock_on = 1;
    prev_btn = 0;
    spring_g = longint'(SPRING_RESET);
    damp_g = longint'(DAMP_RESET);
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    add_row(MODE_SERVO, pack_in(0, 0, 0, 0, 0, 0, 0, 0), 1, pack_out(0, 0, 0, 0, 0, 0, 1, 0));
    add_row(MODE_FEEDBACK, pack_in(0, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0), 1,
            pack_out(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 1, 0));
    add_row(MODE_FEEDBACK, pack_in(32'h7fffffff, 32'h80000000, 12345, 0, 0, 0, 1, 1));
    add_row(MODE_SERVO, pack_in(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 1, 0));
    add_row(MODE_SERVO, pack_in(32'h80000000, 32'h7fffffff, 32'h10000, 0, 0, 0, 1, 1));
    add_row(MODE_SERVO, pack_in(32'h80000000, 32'h7fffffff, 32'h10000, 0, 0, 0, 1, 1));
    add_row(MODE_SERVO, pack_in(0, 0, 0, 0, 0, 0, 0, 1));
    add_row(MODE_SERVO, pack_in(0, 0, 0, 0, 0, 0, 1, 1));
    add_row(MODE_SERVO, pack_in(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(MODE_FEEDBACK, pack_in('1, '1, '1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1, 1));
    add_row(MODE_SERVO, pack_in(32'h100, 32'hffffff00, 32'h8000, 0, 0, 0, 0, 0));
    add_row(MODE_SERVO, pack_in(32'h200, 32'hfffffe00, 32'h9000, '1, '1, '1, 0, 0));
    foreach (rows[i]) send_item(rows[i].mode, rows[i].data, rows[i].typed, rows[i].result);

    sg_set = '{24'hffffff, 24'd0, 24'd0, 24'd671089};
    dg_set = '{24'hffffff, 24'd0, 24'd0, 24'd16777};
    sg_set[2] = 24'($urandom);
    dg_set[2] = 24'($urandom_range(0, 24'hffff));
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_idle();
      reg_write(ADDR_SPRING, sg_set[ph]);
      reg_write(ADDR_DAMP, dg_set[ph]);
      for (int n = 0; n < 110; n++) begin
        md = ($urandom_range(0, 99) < 15);
        for (int a = 0; a < 3; a++) begin
          if ($urandom_range(0, 9) == 0) begin
            walk[a] = longint'($signed($urandom));
          end else begin
            dlt = 64'sd1 <<< $urandom_range(4, 20);
            walk[a] = clip(walk[a] + longint'($urandom_range(0, 2 * dlt)) - dlt, MIN32, MAX32);
          end
          pv[a] = walk[a][31:0];
          cv[a] = $signed($urandom) >>> $urandom_range(0, 24);
        end
        if ($urandom_range(0, 9) < 3) begin
          g = 1'($urandom);
          w = 1'($urandom);
        end else begin
          g = prev_btn[0];
          w = prev_btn[1];
        end
        send_item(md, pack_in(pv[0], pv[1], pv[2], cv[0], cv[1], cv[2], g, w), 0, '0);
      end
    end

    drain_and_idle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("haptic_velocity_filter_spring_lock_unit verification clean");
    end else begin
      $display("haptic_velocity_filter_spring_lock_unit verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/hvsl_pkg.sv
design/hvsl_dp.sv
design/hvsl_ctrl.sv
design/haptic_velocity_filter_spring_lock_unit.sv
tb/haptic_velocity_filter_spring_lock_unit_tb.sv
